// ===== rtl/core/zbuf_pkg.sv =====
// Shared types and constants for the depth-tested color buffer.
`timescale 1ns / 1ps
package zbuf_pkg;

  // Store geometry and field widths
  localparam int MAX_PIXELS = 65536;
  localparam int ADDR_BITS  = $clog2(MAX_PIXELS);
  localparam int DEPTH_BITS = 24;
  localparam int COLOR_BITS = 32;
  localparam int POS_BITS   = 12;
  localparam int REG_BITS   = 9;
  // Signed linear index: y * width + x needs POS_BITS + REG_BITS bits
  localparam int IDX_BITS   = POS_BITS + REG_BITS;
  // Pixel count width * height
  localparam int LIMIT_BITS = 2 * REG_BITS;

  localparam logic [DEPTH_BITS-1:0] DEPTH_FAR = {DEPTH_BITS{1'b1}};

  // Register indexes on the configuration port
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [REG_BITS-1:0] FRAME_RESET = REG_BITS'(256);

  // Request kinds; code 3 is unused
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // latch the request fields
    logic index;       // compute the linear index
    logic fetch;       // range check and memory read
    logic resolve;     // depth test, store, load result
    logic sweep;       // write one cleared entry, advance sweep address
    logic clear_done;  // load the result of a clear
  } ctrl_cmd_t;

endpackage

// ===== rtl/core/zbuf_ctrl.sv =====
// Controller state machine sequencing requests, clears and the reset sweep.
`timescale 1ns / 1ps
module zbuf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         kind,
  input  logic               sweep_last,
  output zbuf_pkg::ctrl_cmd_t cmd,
  output logic               busy,
  output logic               done
);
  import zbuf_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_INDEX,
    ST_FETCH,
    ST_RESOLVE,
    ST_CLEAR
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_next;

  assign busy = (state != ST_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    done_next  = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.sweep = 1'b1;
        if (sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (kind == KIND_CLEAR) begin
            state_next = ST_CLEAR;
          end else begin
            state_next = ST_INDEX;
          end
        end
      end
      ST_INDEX: begin
        cmd.index  = 1'b1;
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        cmd.resolve = 1'b1;
        done_next   = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sweep_last) begin
          cmd.clear_done = 1'b1;
          done_next      = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // A result appears only once the block is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // An accepted request always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start work");

  // One request yields one result, never two in a row
  a_single_done: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe repeated");

  // The datapath sees one command at a time, apart from clear_done, which comes with sweep
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.index, cmd.fetch, cmd.resolve, cmd.sweep}))
    else $error("conflicting datapath commands");

endmodule

// ===== rtl/core/zbuf_datapath.sv =====
// Datapath: frame registers, index arithmetic, pixel memory and result registers.
`timescale 1ns / 1ps
module zbuf_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  zbuf_pkg::ctrl_cmd_t                cmd,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [zbuf_pkg::REG_BITS-1:0]      cfg_data,
  input  logic [1:0]                         kind,
  input  logic [zbuf_pkg::POS_BITS-1:0]      pos_x,
  input  logic [zbuf_pkg::POS_BITS-1:0]      pos_y,
  input  logic [zbuf_pkg::COLOR_BITS-1:0]    pixel_color,
  input  logic [zbuf_pkg::DEPTH_BITS-1:0]    pixel_depth,
  output logic                               sweep_last,
  output logic                               accepted,
  output logic [zbuf_pkg::COLOR_BITS-1:0]    stored_color,
  output logic [zbuf_pkg::DEPTH_BITS-1:0]    stored_depth
);
  import zbuf_pkg::*;

  localparam int WORD_BITS = COLOR_BITS + DEPTH_BITS;

  logic [REG_BITS-1:0]   frame_width;
  logic [REG_BITS-1:0]   frame_height;
  logic [LIMIT_BITS-1:0] limit;

  logic [1:0]            kind_r;
  logic [POS_BITS-1:0]   x_r;
  logic [POS_BITS-1:0]   y_r;
  logic [COLOR_BITS-1:0] color_r;
  logic [DEPTH_BITS-1:0] depth_r;

  logic signed [IDX_BITS-1:0] idx;
  logic signed [IDX_BITS-1:0] x_ext;
  logic signed [IDX_BITS-1:0] y_ext;
  logic signed [IDX_BITS-1:0] w_ext;
  logic                       in_range;
  logic                       in_range_next;

  logic [WORD_BITS-1:0]  mem [MAX_PIXELS];
  logic [WORD_BITS-1:0]  rd_word;
  logic [COLOR_BITS-1:0] rd_color;
  logic [DEPTH_BITS-1:0] rd_depth;
  logic [ADDR_BITS-1:0]  sweep_addr;
  logic [ADDR_BITS-1:0]  pix_addr;
  logic                  store_ok;

  assign rd_color   = rd_word[WORD_BITS-1:DEPTH_BITS];
  assign rd_depth   = rd_word[DEPTH_BITS-1:0];
  assign pix_addr   = idx[ADDR_BITS-1:0];
  assign sweep_last = (sweep_addr == {ADDR_BITS{1'b1}});

  // Frame registers and the registered pixel count
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_RESET;
      frame_height <= FRAME_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= cfg_data;
      end else begin
        frame_height <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    limit <= frame_width * frame_height;
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= kind;
      x_r     <= pos_x;
      y_r     <= pos_y;
      color_r <= pixel_color;
      depth_r <= pixel_depth;
    end
  end

  // Linear index y * width + x, then the range check
  assign x_ext = {{(IDX_BITS-POS_BITS){x_r[POS_BITS-1]}}, x_r};
  assign y_ext = {{(IDX_BITS-POS_BITS){y_r[POS_BITS-1]}}, y_r};
  assign w_ext = {{(IDX_BITS-REG_BITS){1'b0}}, frame_width};

  assign in_range_next = !idx[IDX_BITS-1]
    && (idx[IDX_BITS-2:0] < (IDX_BITS-1)'(limit))
    && (idx[IDX_BITS-2:0] < (IDX_BITS-1)'(MAX_PIXELS));

  always_ff @(posedge clk) begin
    if (cmd.index) begin
      idx <= y_ext * w_ext + x_ext;
    end
    if (cmd.fetch) begin
      in_range <= in_range_next;
    end
  end

  // Depth test: strictly nearer wins
  assign store_ok = (kind_r == KIND_WRITE) && in_range && (depth_r < rd_depth);

  // Sweep address advances one entry per sweep cycle, in the reset sweep and in a clear
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep) begin
      sweep_addr <= sweep_addr + 1'b1;
    end
  end

  // Pixel memory: one write port, one registered read
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      mem[sweep_addr] <= {{COLOR_BITS{1'b0}}, DEPTH_FAR};
    end else if (cmd.resolve && store_ok) begin
      mem[pix_addr] <= {color_r, depth_r};
    end
    if (cmd.fetch) begin
      rd_word <= mem[pix_addr];
    end
  end

  // Load the result
  always_ff @(posedge clk) begin
    if (cmd.clear_done) begin
      accepted     <= 1'b1;
      stored_color <= '0;
      stored_depth <= '0;
    end else if (cmd.resolve) begin
      case (kind_r)
        KIND_WRITE: begin
          accepted     <= store_ok;
          stored_color <= '0;
          stored_depth <= '0;
        end
        KIND_READ: begin
          accepted     <= 1'b0;
          stored_color <= in_range ? rd_color : '0;
          stored_depth <= in_range ? rd_depth : DEPTH_FAR;
        end
        default: begin
          accepted     <= 1'b0;
          stored_color <= '0;
          stored_depth <= DEPTH_FAR;
        end
      endcase
    end
  end

  // A store only lands on an index inside the frame
  a_store_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.resolve && store_ok) |-> (!idx[IDX_BITS-1]
      && (idx[IDX_BITS-2:0] < (IDX_BITS-1)'(MAX_PIXELS))))
    else $error("store outside the frame");

  // The sweep address wraps to zero after the last entry
  a_sweep_wrap: assert property (@(posedge clk) disable iff (rst)
    (cmd.sweep && sweep_last) |=> (sweep_addr == '0))
    else $error("sweep address did not wrap");

  // A rejected write leaves the result flag low
  a_reject: assert property (@(posedge clk) disable iff (rst)
    (cmd.resolve && !store_ok) |=> !accepted)
    else $error("rejected request reported as accepted");

endmodule

// ===== rtl/core/depth_tested_color_buffer.sv =====
// Top level of the depth-tested color buffer: controller plus datapath.
`timescale 1ns / 1ps
// Usage
//   Requests: drive kind, pos_x, pos_y, pixel_color and pixel_depth with start high;
//   the request is taken at a rising edge where start is high and busy is low.
//   kind selects a depth-tested write, a clear of the whole buffer or a pixel read.
//   Results: done is high for exactly one cycle with accepted, stored_color and
//   stored_depth valid; the receiver must take them in that cycle.
//   Configuration: cfg_we writes cfg_data to frame_width (index 0) or frame_height
//   (index 1), for use only while busy is low and no result is pending (unenforced).
// Sequencing
//   Write or read: the request is captured, then come the index multiply, the
//   range check with memory read and the depth test; no new request is taken
//   until done, and the next may be taken in the cycle where done is high.
//   Clear: the single memory write port sweeps all 65536 entries, one per cycle;
//   done is raised as the last entry is written.
// Reset
//   After rst the same sweep sets every color to 0 and every depth to far;
//   busy stays high until the sweep ends and no result is produced for it.
module depth_tested_color_buffer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      kind,
  input  logic [zbuf_pkg::POS_BITS-1:0]   pos_x,
  input  logic [zbuf_pkg::POS_BITS-1:0]   pos_y,
  input  logic [zbuf_pkg::COLOR_BITS-1:0] pixel_color,
  input  logic [zbuf_pkg::DEPTH_BITS-1:0] pixel_depth,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [zbuf_pkg::REG_BITS-1:0]   cfg_data,
  output logic                            done,
  output logic                            accepted,
  output logic [zbuf_pkg::COLOR_BITS-1:0] stored_color,
  output logic [zbuf_pkg::DEPTH_BITS-1:0] stored_depth
);
  import zbuf_pkg::*;

  ctrl_cmd_t cmd;
  logic      sweep_last;

  // Sequence requests
  zbuf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .kind       (kind),
    .sweep_last (sweep_last),
    .cmd        (cmd),
    .busy       (busy),
    .done       (done)
  );

  // Compute, store and report
  zbuf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .kind         (kind),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pixel_color  (pixel_color),
    .pixel_depth  (pixel_depth),
    .sweep_last   (sweep_last),
    .accepted     (accepted),
    .stored_color (stored_color),
    .stored_depth (stored_depth)
  );

endmodule
